// File: sv/base64_stream_encoder_top_assert.svh
// assertion macros used by the base64 stream encoder queue module
`ifndef BASE64_STREAM_ENCODER_TOP_ASSERT_SVH
`define BASE64_STREAM_ENCODER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define B64E_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define B64E_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/b64e_pkg.sv
// types, constants and the alphabet function of the base64 stream encoder
package b64e_pkg;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;
	localparam logic [7:0] CHAR_SLASH   = 8'h2F;
	localparam logic [7:0] PAD_CHAR     = 8'h3D;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_last;
	} in_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_last;
	} out_t;

	// one classified item: up to four characters ready to send
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic [1:0]      n_m1;
		logic            last;
	} job_t;

	function automatic logic [7:0] enc(input logic [5:0] six);
		logic [7:0] v;
		v = {2'b00, six};
		if (six < 6'd26) begin
			return CHAR_UPPER_A + v;
		end else if (six < 6'd52) begin
			return CHAR_LOWER_A + (v - 8'd26);
		end else if (six < 6'd62) begin
			return CHAR_DIGIT_0 + (v - 8'd52);
		end else if (six == 6'd62) begin
			return CHAR_PLUS;
		end else begin
			return CHAR_SLASH;
		end
	endfunction

endpackage

// File: sv/b64e_front.sv
// front end: accepts bytes, tracks the group position and builds character jobs
module b64e_front import b64e_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic push,
	output job_t push_job,
	input  logic q_full
);

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_ONE   = 2'd1,
		PH_TWO   = 2'd2
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [3:0] carry_q, carry_d;
	logic [7:0] b;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;
	assign b        = in_data.data_byte;

	always_comb begin
		push_job       = '0;
		push_job.last  = in_data.is_last;
		phase_d        = PH_START;
		carry_d        = 4'd0;
		case (phase_q)
			PH_ONE: begin
				push_job.chars[0] = enc({carry_q[1:0], b[7:4]});
				if (in_data.is_last) begin
					push_job.chars[1] = enc({b[3:0], 2'b00});
					push_job.chars[2] = PAD_CHAR;
					push_job.n_m1     = 2'd2;
				end else begin
					push_job.n_m1 = 2'd0;
					phase_d       = PH_TWO;
					carry_d       = b[3:0];
				end
			end
			PH_TWO: begin
				push_job.chars[0] = enc({carry_q, b[7:6]});
				push_job.chars[1] = enc(b[5:0]);
				push_job.n_m1     = 2'd1;
			end
			default: begin
				// start of group, also the unused phase code
				push_job.chars[0] = enc(b[7:2]);
				if (in_data.is_last) begin
					push_job.chars[1] = enc({b[1:0], 4'b0000});
					push_job.chars[2] = PAD_CHAR;
					push_job.chars[3] = PAD_CHAR;
					push_job.n_m1     = 2'd3;
				end else begin
					push_job.n_m1 = 2'd0;
					phase_d       = PH_ONE;
					carry_d       = {2'b00, b[1:0]};
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			carry_q <= 4'd0;
		end else if (push) begin
			phase_q <= phase_d;
			carry_q <= carry_d;
		end
	end

endmodule

// File: sv/b64e_queue.sv
// short job queue between the front end and the character sender
`include "base64_stream_encoder_top_assert.svh"

module b64e_queue import b64e_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic q_full,
	input  logic pop,
	output logic head_valid,
	output job_t head_job
);

	job_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign q_full     = (cnt_q == QCNT_W'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`B64E_ASSERT_NOW(a_no_push_full, push, !q_full, "job pushed into a full queue")
	`B64E_ASSERT_NOW(a_no_pop_empty, pop, head_valid, "job popped from an empty queue")
	`B64E_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= QCNT_W'(QDEPTH), "queue count out of range")
	`B64E_ASSERT_NEXT(a_push_grows, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "queue count did not grow on push")

endmodule

// File: sv/b64e_back.sv
// back end: sends the characters of each job one per cycle, while the output is not stalled, through an output register
module b64e_back import b64e_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  job_t head_job,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	out_t       out_q;
	logic       load;
	logic       final_char;

	assign load       = head_valid && (!out_valid_q || out_ready);
	assign final_char = (idx_q == head_job.n_m1);
	assign pop        = load && final_char;
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_char <= head_job.chars[idx_q];
			out_q.out_last <= head_job.last && final_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= final_char ? 2'd0 : idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: sv/base64_stream_encoder_top.sv
// the first character of an item is registered in a queue entry and then in the output register
// throughput: one character per cycle out of the output register while not stalled, so a
// byte every cycle while each yields one character; three bytes yield four characters
// a two-entry job queue lets input accept go on while the output is stalled, until it fills
// reset (arst_n low, asynchronous) clears group position, carried bits, queue and output valid
module base64_stream_encoder_top import b64e_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	logic push;
	job_t push_job;
	logic q_full;
	logic pop;
	logic head_valid;
	job_t head_job;

	b64e_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.push     (push),
		.push_job (push_job),
		.q_full   (q_full)
	);

	b64e_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.q_full     (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	b64e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
